// ===== hw/rtl/rlee_pkg.sv =====
// ----------------------------------------------------------------------------
// rlee_pkg
// Types, constants and helpers for the run-length escape encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rlee_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned CntW  = 7;

  // Longest run held before it is forced closed (keeps the count to two digits)
  localparam logic [CntW-1:0] MaxRun = 7'd99;
  // Runs up to this length go out as plain copies
  localparam logic [CntW-1:0] LitLimit = 7'd4;

  localparam logic [CharW-1:0] EscChar  = 8'h2F;  // '/'
  localparam logic [CharW-1:0] ZeroChar = 8'h30;  // '0'

  typedef struct packed {
    logic [CharW-1:0] sym;
    logic [CntW-1:0]  cnt;
  } run_t;

  function automatic logic is_valid_byte(input logic [CharW-1:0] b);
    logic ok;
    ok = ((b >= 8'h61) && (b <= 8'h7A)) ||
         ((b >= 8'h41) && (b <= 8'h5A)) ||
         ((b >= 8'h30) && (b <= 8'h39)) ||
         (b == 8'h20) || (b == 8'h2B) || (b == 8'h3D) || (b == 8'h2C) ||
         (b == 8'h2E) || (b == 8'h7B) || (b == 8'h7D) || (b == 8'h5B) ||
         (b == 8'h5D) || (b == 8'h3A) || (b == 8'h3B) || (b == 8'h27);
    return ok;
  endfunction

  // Tens digit, count / 10, by reciprocal multiply; exact for any 7-bit count
  function automatic logic [3:0] tens_digit(input logic [CntW-1:0] c);
    logic [14:0] p;
    p = 15'(c) * 15'd205;
    return p[14:11];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rlee_in_if.sv =====
// ----------------------------------------------------------------------------
// rlee_in_if
// Input channel: one string byte per beat with an end-of-string flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlee_in_if;
  import rlee_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_in;
  logic             end_of_string;

  modport source (output valid, output char_in, output end_of_string, input ready);
  modport sink   (input valid, input char_in, input end_of_string, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rlee_out_if.sv =====
// ----------------------------------------------------------------------------
// rlee_out_if
// Output channel: one encoded byte per beat, flagged on the last of an item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rlee_out_if;
  import rlee_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] byte_out;
  logic             last_of_item;

  modport source (output valid, output byte_out, output last_of_item, input ready);
  modport sink   (input valid, input byte_out, input last_of_item, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/run_length_escape_encoder.sv =====
// ----------------------------------------------------------------------------
// run_length_escape_encoder
// Run-length encoder with '/NN' escapes for runs longer than four bytes.
// ----------------------------------------------------------------------------
// A taken input beat loads the pending job registers; the output byte register is
// loaded from them. Throughput: one input beat per cycle while each causes at most
// one output beat and the output is not stalled; an item with more output beats
// holds the input until its last beat enters the single output byte register.
// Reset clears the run state, the pending job flags and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module run_length_escape_encoder
  import rlee_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  rlee_in_if.sink     in_i,
  rlee_out_if.source  out_o
);

  // run state
  logic [CharW-1:0] prev_q, prev_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             have_q, have_d;

  // pending job: up to two runs to emit
  logic             pend_q;
  run_t             run0_q, run1_q;
  logic             run1_v_q;
  logic             sel_q;
  logic [1:0]       idx_q;

  // output register
  logic             out_valid_q;
  logic [CharW-1:0] out_byte_q;
  logic             out_last_q;

  // ---- input side: run tracking ----
  logic       accept;
  logic       close_a, fin;
  run_t       run_a, run_f;
  logic       has_job;

  always_comb begin
    prev_d  = prev_q;
    cnt_d   = cnt_q;
    have_d  = have_q;
    close_a = 1'b0;
    run_a   = '{sym: prev_q, cnt: cnt_q};
    if (!have_q) begin
      prev_d = in_i.char_in;
      cnt_d  = 7'd1;
      have_d = 1'b1;
    end else if (is_valid_byte(in_i.char_in) && (in_i.char_in == prev_q) &&
                 (cnt_q < MaxRun)) begin
      cnt_d = cnt_q + 7'd1;
    end else begin
      close_a = 1'b1;
      prev_d  = in_i.char_in;
      cnt_d   = 7'd1;
    end
    run_f = '{sym: prev_d, cnt: cnt_d};
    fin   = 1'b0;
    if (in_i.end_of_string) begin
      fin    = is_valid_byte(prev_d);
      have_d = 1'b0;
      cnt_d  = '0;
    end
  end

  assign has_job = close_a || fin;

  // ---- emitter ----
  run_t       cur;
  logic       esc;
  logic [2:0] len;
  logic [3:0] tens, ones;
  logic [6:0] tens_x10;
  logic [CharW-1:0] cur_byte;
  logic       run_end, job_end, adv;

  always_comb begin
    cur      = sel_q ? run1_q : run0_q;
    esc      = cur.cnt > LitLimit;
    len      = esc ? 3'd4 : cur.cnt[2:0];
    tens     = tens_digit(cur.cnt);
    tens_x10 = 7'(tens) * 7'd10;
    ones     = 4'(cur.cnt - tens_x10);
    cur_byte = cur.sym;
    if (esc) begin
      unique case (idx_q)
        2'd0:    cur_byte = EscChar;
        2'd1:    cur_byte = ZeroChar + 8'(tens);
        2'd2:    cur_byte = ZeroChar + 8'(ones);
        default: cur_byte = cur.sym;
      endcase
    end
    run_end = ({1'b0, idx_q} == (len - 3'd1));
    job_end = run_end && (sel_q || !run1_v_q);
  end

  assign adv        = pend_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !pend_q || (adv && job_end);
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      cnt_q       <= '0;
      have_q      <= 1'b0;
      pend_q      <= 1'b0;
      run1_v_q    <= 1'b0;
      sel_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        prev_q <= prev_d;
        cnt_q  <= cnt_d;
        have_q <= have_d;
      end
      // a new job only arrives when none is pending or the current one ends in this cycle
      if (accept && has_job) begin
        pend_q   <= 1'b1;
        sel_q    <= 1'b0;
        idx_q    <= '0;
        run1_v_q <= close_a && fin;
      end else if (adv) begin
        if (run_end) begin
          if (!sel_q && run1_v_q) begin
            sel_q <= 1'b1;
            idx_q <= '0;
          end else begin
            pend_q <= 1'b0;
          end
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q <= cur_byte;
      out_last_q <= job_end;
    end
    if (accept && has_job) begin
      run0_q <= close_a ? run_a : run_f;
      run1_q <= run_f;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.byte_out     = out_byte_q;
  assign out_o.last_of_item = out_last_q;

endmodule

`default_nettype wire

// ===== tb/tb_run_length_escape_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_run_length_escape_encoder
// Drives strings through the encoder and checks every encoded beat in order
// against a scoreboard that tracks the run state on its own. Directed strings
// cover literal runs, escapes, invalid bytes and a run forced closed at the
// cap (with idling on). Random strings follow with bursts of idling on both
// channels, one long receiver hold-off, and a closing stretch at full rate.
// ----------------------------------------------------------------------------

module tb_run_length_escape_encoder;
  import rlee_pkg::*;

  localparam int    RunLimitCycles = 200000;
  localparam int    HoldOffCycles  = 300;
  localparam string ValidSet =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789 +=,.{}[]:;'";

  typedef struct packed {
    logic [CharW-1:0] sym;
    logic             tail;
  } enc_beat_t;

  class rle_scoreboard;
    logic [CharW-1:0] run_sym;
    logic [CntW-1:0]  run_len;
    bit               run_open;
    bit               legal_sym[256];
    enc_beat_t        pending_q[$];
    int               mismatches;

    function new();
      run_sym    = '0;
      run_len    = '0;
      run_open   = 1'b0;
      mismatches = 0;
      foreach (legal_sym[i]) legal_sym[i] = 1'b0;
      for (int i = 0; i < ValidSet.len(); i++) legal_sym[ValidSet[i]] = 1'b1;
    endfunction

    function void push_sym(input logic [CharW-1:0] s);
      enc_beat_t b;
      b.sym  = s;
      b.tail = 1'b0;
      pending_q.push_back(b);
    endfunction

    function void close_run(input logic [CntW-1:0] len, input logic [CharW-1:0] s);
      logic [CharW-1:0] tens, ones;
      tens = CharW'((len / 10) % 10);
      ones = CharW'(len % 10);
      if (len <= LitLimit) begin
        for (int i = 0; i < len; i++) push_sym(s);
      end else begin
        push_sym(EscChar);
        push_sym(ZeroChar + tens);
        push_sym(ZeroChar + ones);
        push_sym(s);
      end
    endfunction

    // Accepted input beat: advance the run and queue whatever it closes.
    function void note_char(input logic [CharW-1:0] ch, input logic eos);
      int base;
      base = pending_q.size();
      if (!run_open) begin
        run_sym  = ch;
        run_len  = 7'd1;
        run_open = 1'b1;
      end else if (legal_sym[ch] && ch == run_sym && run_len < MaxRun) begin
        run_len = run_len + 7'd1;
      end else begin
        close_run(run_len, run_sym);
        run_sym = ch;
        run_len = 7'd1;
      end
      if (eos) begin
        if (legal_sym[run_sym]) close_run(run_len, run_sym);
        run_open = 1'b0;
        run_len  = '0;
      end
      if (pending_q.size() > base) pending_q[pending_q.size() - 1].tail = 1'b1;
    endfunction

    function void check_beat(input logic [CharW-1:0] got_sym, input logic got_tail);
      enc_beat_t want;
      if (pending_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected beat: byte %h tail %b", got_sym, got_tail);
        mismatches++;
        return;
      end
      want = pending_q.pop_front();
      if (want.sym !== got_sym || want.tail !== got_tail) begin
        if (mismatches < 10)
          $display("mismatch: expected byte %h tail %b, got byte %h tail %b",
                   want.sym, want.tail, got_sym, got_tail);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   gaps_on;
  bit   stalls_on;
  bit   hold_req;
  int   items_sent;
  int   cycle_cnt;

  rle_scoreboard sb;

  rlee_in_if  in_if ();
  rlee_out_if out_if ();

  run_length_escape_encoder dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= RunLimitCycles) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_beat(out_if.byte_out, out_if.last_of_item);
  end

  // Receiver side: random stall bursts and one long hold-off.
  initial begin : rx_side
    int  stall_left;
    int  hold_left;
    bit  hold_taken;
    stall_left   = 0;
    hold_left    = 0;
    hold_taken   = 1'b0;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_char(input logic [CharW-1:0] ch, input logic eos);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.char_in       <= ch;
    in_if.end_of_string <= eos;
    do @(posedge clk); while (!in_if.ready);
    sb.note_char(ch, eos);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_run_string(input logic [CharW-1:0] ch, input int len);
    for (int i = 0; i < len; i++) send_char(ch, i == len - 1);
  endtask

  task automatic send_random_string();
    int               n_runs;
    int               len;
    logic [CharW-1:0] ch;
    if ($urandom_range(0, 9) == 0) begin
      send_char(CharW'($urandom_range(0, 255)), 1'b1);
      return;
    end
    n_runs = $urandom_range(1, 6);
    for (int r = 0; r < n_runs; r++) begin
      if ($urandom_range(0, 4) == 0) begin
        ch  = CharW'($urandom_range(0, 255));
        len = $urandom_range(1, 3);
      end else begin
        ch  = ValidSet[$urandom_range(0, ValidSet.len() - 1)];
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 6);
      end
      for (int k = 0; k < len; k++) send_char(ch, (r == n_runs - 1) && (k == len - 1));
    end
  endtask

  initial begin
    sb                  = new();
    cycle_cnt           = 0;
    items_sent          = 0;
    gaps_on             = 1'b0;
    stalls_on           = 1'b0;
    hold_req            = 1'b0;
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.char_in       = '0;
    in_if.end_of_string = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed strings
    send_text("a");
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b0);
    send_char(8'hFF, 1'b1);
    send_text("zzzz");
    send_text("ZZZZZ");
    send_text("  '{");
    repeat (7) send_char("}", 1'b0);
    send_char(8'h80, 1'b1);

    // a run past the cap, then random strings with idling on both sides
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    send_run_string("k", 101);
    while (items_sent < 300) begin
      if (items_sent >= 160) hold_req = 1'b1;
      send_random_string();
    end

    // full rate to the end
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    while (items_sent < 420) send_random_string();
    @(negedge clk);
    in_if.valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rlee_pkg.sv
hw/rtl/rlee_in_if.sv
hw/rtl/rlee_out_if.sv
hw/rtl/run_length_escape_encoder.sv
tb/tb_run_length_escape_encoder.sv
